// File: hw/rtl/one_wire_pulse_width_sender_unit_macros.svh
// ----------------------------------------------------------------------------
// One-wire pulse-width sender: assertion macros
// Concurrent check wrappers sampled on clk, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_PULSE_WIDTH_SENDER_UNIT_MACROS_SVH
`define ONE_WIRE_PULSE_WIDTH_SENDER_UNIT_MACROS_SVH

// Check masked while reset is asserted.
`define OWPWS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds across reset.
`define OWPWS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/owpws_pkg.sv
// ----------------------------------------------------------------------------
// owpws_pkg
// Shared types, codes and reset values for the one-wire pulse-width sender.
// ----------------------------------------------------------------------------
package owpws_pkg;

  localparam int DATA_BITS_DEF = 8;

  localparam int CNT_W   = 16;
  localparam int DUR_W   = 12;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;

  // Opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_START_LOW = 2'd0;
  localparam logic [CIDX_W-1:0] REG_LONG      = 2'd1;
  localparam logic [CIDX_W-1:0] REG_SHORT     = 2'd2;

  // Phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;
  localparam logic [1:0] PH_LOW   = 2'd3;

  // Register reset values
  localparam logic [CNT_W-1:0] START_LOW_RST = 16'd5000;
  localparam logic [DUR_W-1:0] LONG_RST      = 12'd600;
  localparam logic [DUR_W-1:0] SHORT_RST     = 12'd200;

  typedef struct packed {
    logic [CNT_W-1:0] start_low_ticks;
    logic [DUR_W-1:0] long_ticks;
    logic [DUR_W-1:0] short_ticks;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] shift_byte;
    logic [1:0]        phase;
    logic [CNT_W-1:0]  tick_count;
    logic              wire_level;
  } state_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
  } result_t;

endpackage

// File: hw/rtl/owpws_step.sv
// ----------------------------------------------------------------------------
// owpws_step
// Next-state logic: one tick or one send request applied to the sender state.
// ----------------------------------------------------------------------------
module owpws_step #(
  parameter int DATA_BITS = owpws_pkg::DATA_BITS_DEF,
  localparam int BL_W = $clog2(DATA_BITS + 1)
) (
  input  owpws_pkg::cfg_t              cfg,
  input  owpws_pkg::state_t            cur,
  input  logic [BL_W-1:0]              bits_left,
  input  logic                         opcode,
  input  logic [owpws_pkg::BYTE_W-1:0] data_byte,
  output owpws_pkg::state_t            nxt,
  output logic [BL_W-1:0]              bits_left_nxt,
  output owpws_pkg::result_t           res
);

  logic [owpws_pkg::CNT_W-1:0] cnt_inc;
  logic [owpws_pkg::CNT_W-1:0] start_len;
  logic [owpws_pkg::CNT_W-1:0] long_len;
  logic [owpws_pkg::CNT_W-1:0] short_len;
  logic [owpws_pkg::CNT_W-1:0] hi_len;
  logic [owpws_pkg::CNT_W-1:0] lo_len;
  logic [BL_W-1:0]             bl_dec;
  logic                        acc;

  // Zero durations behave as one tick.
  assign start_len = (cfg.start_low_ticks == '0) ? owpws_pkg::CNT_W'(1)
                                                 : cfg.start_low_ticks;
  assign long_len  = (cfg.long_ticks == '0) ? owpws_pkg::CNT_W'(1)
                                            : owpws_pkg::CNT_W'(cfg.long_ticks);
  assign short_len = (cfg.short_ticks == '0) ? owpws_pkg::CNT_W'(1)
                                             : owpws_pkg::CNT_W'(cfg.short_ticks);
  assign hi_len    = cur.shift_byte[0] ? long_len : short_len;
  assign lo_len    = cur.shift_byte[0] ? short_len : long_len;
  assign cnt_inc   = cur.tick_count + owpws_pkg::CNT_W'(1);
  assign bl_dec    = (bits_left != '0) ? bits_left - BL_W'(1) : '0;

  always_comb begin
    nxt           = cur;
    bits_left_nxt = bits_left;
    acc           = 1'b0;
    if (opcode == owpws_pkg::OP_SEND) begin
      if (cur.phase == owpws_pkg::PH_IDLE) begin
        nxt.shift_byte = data_byte;
        nxt.phase      = owpws_pkg::PH_START;
        nxt.tick_count = '0;
        nxt.wire_level = 1'b0;
        bits_left_nxt  = BL_W'(DATA_BITS);
        acc            = 1'b1;
      end
    end else if (cur.phase != owpws_pkg::PH_IDLE) begin
      nxt.tick_count = cnt_inc;
      case (cur.phase)
        owpws_pkg::PH_START: begin
          if (cnt_inc >= start_len) begin
            nxt.phase      = owpws_pkg::PH_HIGH;
            nxt.wire_level = 1'b1;
            nxt.tick_count = '0;
          end
        end
        owpws_pkg::PH_HIGH: begin
          if (cnt_inc >= hi_len) begin
            nxt.phase      = owpws_pkg::PH_LOW;
            nxt.wire_level = 1'b0;
            nxt.tick_count = '0;
          end
        end
        owpws_pkg::PH_LOW: begin
          if (cnt_inc >= lo_len) begin
            nxt.shift_byte = cur.shift_byte >> 1;
            nxt.tick_count = '0;
            nxt.wire_level = 1'b1;
            nxt.phase      = (bl_dec == '0) ? owpws_pkg::PH_IDLE : owpws_pkg::PH_HIGH;
            bits_left_nxt  = bl_dec;
          end
        end
        default: ;
      endcase
    end
  end

  assign res.line_level = nxt.wire_level;
  assign res.busy_res   = (nxt.phase != owpws_pkg::PH_IDLE);
  assign res.accepted   = acc;

endmodule

// File: hw/rtl/one_wire_pulse_width_sender_unit.sv
// ----------------------------------------------------------------------------
// one_wire_pulse_width_sender_unit
// Pulse-width coded byte sender for a single data wire, one beat per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry in_opcode (tick or send) and in_data_byte. Each input
//   beat yields exactly one output beat with the wire level, busy flag and
//   whether a send was taken. A send while busy is refused (accepted = 0).
//   Beats pass an input register, then the next-state logic, then the result
//   register. One beat is taken every cycle when the receiver keeps
//   out_ready high. The user is to write the timing registers through
//   cfg_we/cfg_index/cfg_wdata only while no beats are in flight; the block
//   does not enforce this. Unknown indexes are ignored.
//   Reset (rst_n low, synchronous) empties both registers, puts the line
//   idle high and restores the timing registers to 5000/600/200 ticks.
//   When the receiver stalls, the result register holds its beat and the
//   input register takes one more beat, then in_ready drops until the
//   result beat is taken.
// ----------------------------------------------------------------------------
`include "one_wire_pulse_width_sender_unit_macros.svh"

module one_wire_pulse_width_sender_unit #(
  parameter int DATA_BITS = owpws_pkg::DATA_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [owpws_pkg::BYTE_W-1:0]  in_data_byte,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_line_level,
  output logic                          out_busy_res,
  output logic                          out_accepted,

  input  logic                          cfg_we,
  input  logic [owpws_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [owpws_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int BL_W = $clog2(DATA_BITS + 1);

  owpws_pkg::cfg_t    cfg_r;
  owpws_pkg::state_t  state_r;
  owpws_pkg::state_t  state_nxt;
  owpws_pkg::result_t res_nxt;
  owpws_pkg::result_t res_r;
  logic [BL_W-1:0]    bits_left_r;
  logic [BL_W-1:0]    bits_left_nxt;

  logic                        in_valid_r;
  logic                        in_opcode_r;
  logic [owpws_pkg::BYTE_W-1:0] in_data_byte_r;
  logic                        out_valid_r;
  logic                        adv;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_ticks <= owpws_pkg::START_LOW_RST;
      cfg_r.long_ticks      <= owpws_pkg::LONG_RST;
      cfg_r.short_ticks     <= owpws_pkg::SHORT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        owpws_pkg::REG_START_LOW: cfg_r.start_low_ticks <= cfg_wdata;
        owpws_pkg::REG_LONG:      cfg_r.long_ticks  <= cfg_wdata[owpws_pkg::DUR_W-1:0];
        owpws_pkg::REG_SHORT:     cfg_r.short_ticks <= cfg_wdata[owpws_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_opcode_r    <= in_opcode;
      in_data_byte_r <= in_data_byte;
    end
  end

  owpws_step #(
    .DATA_BITS (DATA_BITS)
  ) u_step (
    .cfg           (cfg_r),
    .cur           (state_r),
    .bits_left     (bits_left_r),
    .opcode        (in_opcode_r),
    .data_byte     (in_data_byte_r),
    .nxt           (state_nxt),
    .bits_left_nxt (bits_left_nxt),
    .res           (res_nxt)
  );

  // Sender state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.shift_byte <= '0;
      state_r.phase      <= owpws_pkg::PH_IDLE;
      state_r.tick_count <= '0;
      state_r.wire_level <= 1'b1;
      bits_left_r        <= '0;
      out_valid_r        <= 1'b0;
    end else if (adv && in_valid_r) begin
      state_r     <= state_nxt;
      bits_left_r <= bits_left_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_level = res_r.line_level;
  assign out_busy_res   = res_r.busy_res;
  assign out_accepted   = res_r.accepted;

  `OWPWS_ASSERT(a_idle_line_high, (state_r.phase == owpws_pkg::PH_IDLE) |-> state_r.wire_level, "line low while idle")
  `OWPWS_ASSERT(a_accept_busy, (out_valid_r && res_r.accepted) |-> res_r.busy_res, "accepted send not busy")
  `OWPWS_ASSERT(a_held_input, (in_valid_r && !adv) |=> (in_valid_r && $stable(in_opcode_r) && $stable(in_data_byte_r)), "input register lost a beat")
  `OWPWS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!in_valid_r && !out_valid_r), "pipeline not empty after reset")

endmodule

// File: bench/one_wire_pulse_width_sender_unit_test.sv
// ----------------------------------------------------------------------------
// one_wire_pulse_width_sender_unit_test
// Drives tick and send beats into the pulse-width sender under random
// back-pressure. A cycle-level shadow of the sender's timer, shift register
// and line level predicts every result beat, and each one is checked field
// by field in arrival order. Timing registers are rewritten between stretches
// of traffic, sometimes in the middle of a transfer, including zero and
// full-scale values.
// ----------------------------------------------------------------------------
module one_wire_pulse_width_sender_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [owpws_pkg::CIDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int USEFUL_TARGET = 1200;
  localparam int MIN_PHASES = 6;

  typedef struct {
    logic                         op;
    logic [owpws_pkg::BYTE_W-1:0] data;
  } wire_cmd_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_opcode = owpws_pkg::OP_TICK;
  logic [owpws_pkg::BYTE_W-1:0] in_data_byte = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic out_line_level;
  logic out_busy_res;
  logic out_accepted;

  logic                         cfg_we = 1'b0;
  logic [owpws_pkg::CIDX_W-1:0] cfg_index = owpws_pkg::REG_START_LOW;
  logic [owpws_pkg::CFG_W-1:0]  cfg_wdata = '0;

  one_wire_pulse_width_sender_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_line_level (out_line_level),
    .out_busy_res   (out_busy_res),
    .out_accepted   (out_accepted),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // shadow timing registers
  logic [owpws_pkg::CNT_W-1:0] tm_start = owpws_pkg::START_LOW_RST;
  logic [owpws_pkg::DUR_W-1:0] tm_long  = owpws_pkg::LONG_RST;
  logic [owpws_pkg::DUR_W-1:0] tm_short = owpws_pkg::SHORT_RST;

  // shadow sender state
  logic [owpws_pkg::BYTE_W-1:0] sh_byte   = '0;
  logic [4:0]                   bits_left = '0;
  logic [1:0]                   ph        = owpws_pkg::PH_IDLE;
  logic [owpws_pkg::CNT_W-1:0]  ticks     = '0;
  logic                         line_lvl  = 1'b1;

  wire_cmd_t          cmd_backlog[$];
  wire_cmd_t          next_cmd;
  owpws_pkg::result_t owed_line_states[$];
  owpws_pkg::result_t got_beat;
  owpws_pkg::result_t want_beat;

  logic in_took = 1'b0;
  bit   calm = 1'b0;
  int   hold_req = 0;
  int   hold_done = 0;
  int   hold_left = 0;
  int   bad_beats = 0;
  int   cycle_count = 0;
  int   useful = 0;
  int   phase_no = 0;
  int   r;

  function automatic int at_least_one(input logic [owpws_pkg::CNT_W-1:0] v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  function automatic owpws_pkg::result_t sender_step(input logic op,
                                                     input logic [owpws_pkg::BYTE_W-1:0] d);
    owpws_pkg::result_t res;
    int                 len;
    res.accepted = 1'b0;
    if (op == owpws_pkg::OP_SEND) begin
      if (ph == owpws_pkg::PH_IDLE) begin
        sh_byte   = d;
        bits_left = 5'(owpws_pkg::DATA_BITS_DEF);
        ph        = owpws_pkg::PH_START;
        ticks     = '0;
        line_lvl  = 1'b0;
        res.accepted = 1'b1;
      end
    end else if (ph != owpws_pkg::PH_IDLE) begin
      ticks = ticks + 1'b1;
      case (ph)
        owpws_pkg::PH_START: begin
          if (int'(ticks) >= at_least_one(tm_start)) begin
            ph = owpws_pkg::PH_HIGH;
            line_lvl = 1'b1;
            ticks = '0;
          end
        end
        owpws_pkg::PH_HIGH: begin
          len = at_least_one(sh_byte[0] ? tm_long : tm_short);
          if (int'(ticks) >= len) begin
            ph = owpws_pkg::PH_LOW;
            line_lvl = 1'b0;
            ticks = '0;
          end
        end
        default: begin
          len = at_least_one(sh_byte[0] ? tm_short : tm_long);
          if (int'(ticks) >= len) begin
            sh_byte = sh_byte >> 1;
            if (bits_left != 0) bits_left = bits_left - 1'b1;
            ticks = '0;
            line_lvl = 1'b1;
            ph = (bits_left == 0) ? owpws_pkg::PH_IDLE : owpws_pkg::PH_HIGH;
          end
        end
      endcase
    end
    res.line_level = line_lvl;
    res.busy_res   = (ph != owpws_pkg::PH_IDLE);
    return res;
  endfunction

  // ticks for one complete transfer at the current timing
  function automatic int transfer_span();
    return at_least_one(tm_start)
         + owpws_pkg::DATA_BITS_DEF * (at_least_one(tm_long) + at_least_one(tm_short));
  endfunction

  task automatic push_cmd(input logic op, input logic [owpws_pkg::BYTE_W-1:0] d);
    wire_cmd_t c;
    c.op = op;
    c.data = d;
    cmd_backlog.push_back(c);
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_cmd(owpws_pkg::OP_TICK, 8'($urandom));
  endtask

  task automatic write_timing(input logic [owpws_pkg::CIDX_W-1:0] idx,
                              input logic [owpws_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // wait until the backlog is sent and every owed beat is back, then the pipe settles
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (cmd_backlog.size() != 0 || in_valid || owed_line_states.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_transfer(input logic [owpws_pkg::BYTE_W-1:0] b, input bit broken);
    int span;
    span = transfer_span();
    if (broken) span = $urandom_range(span - 1, 0);
    else useful += span + 1;
    push_cmd(owpws_pkg::OP_SEND, b);
    for (int i = 0; i < span; i++) begin
      if ($urandom_range(99) < 4) push_cmd(owpws_pkg::OP_SEND, 8'($urandom));
      push_cmd(owpws_pkg::OP_TICK, 8'($urandom));
    end
    push_ticks($urandom_range(3));
  endtask

  // full-scale timing, then shrink it under a running transfer
  task automatic stretch_then_shrink(input logic [owpws_pkg::BYTE_W-1:0] b);
    write_timing(owpws_pkg::REG_START_LOW, 16'hFFFF);
    write_timing(owpws_pkg::REG_LONG, 16'hFFFF);
    write_timing(owpws_pkg::REG_SHORT, 16'hFFFF);
    push_cmd(owpws_pkg::OP_SEND, b);
    push_ticks(40);
    drain();
    write_timing(owpws_pkg::REG_START_LOW, 16'd2);
    push_ticks(12);
    drain();
    write_timing(owpws_pkg::REG_LONG, 16'd1);
    write_timing(owpws_pkg::REG_SHORT, 16'd1);
    push_ticks(2 * owpws_pkg::DATA_BITS_DEF + 3);
    useful += 2 * owpws_pkg::DATA_BITS_DEF + 56;
    drain();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("one_wire_pulse_width_sender_unit test failed");
      $finish;
    end
  end

  // sender side
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
        next_cmd = cmd_backlog.pop_front();
        in_valid     <= 1'b1;
        in_opcode    <= next_cmd.op;
        in_data_byte <= next_cmd.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver side
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_OFF_CYCLES;
      hold_done <= hold_req;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  // shadow update on each input beat and check on each result beat
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got_beat.line_level = out_line_level;
        got_beat.busy_res   = out_busy_res;
        got_beat.accepted   = out_accepted;
        if (owed_line_states.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("unexpected result beat: line=%0b busy=%0b acc=%0b",
                     got_beat.line_level, got_beat.busy_res, got_beat.accepted);
        end else begin
          want_beat = owed_line_states.pop_front();
          if (want_beat.line_level !== got_beat.line_level ||
              want_beat.busy_res !== got_beat.busy_res ||
              want_beat.accepted !== got_beat.accepted) begin
            bad_beats++;
            if (bad_beats <= 10)
              $display("result mismatch: expected line=%0b busy=%0b acc=%0b, got line=%0b busy=%0b acc=%0b",
                       want_beat.line_level, want_beat.busy_res, want_beat.accepted,
                       got_beat.line_level, got_beat.busy_res, got_beat.accepted);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          owpws_pkg::REG_START_LOW: tm_start = cfg_wdata;
          owpws_pkg::REG_LONG:      tm_long  = cfg_wdata[owpws_pkg::DUR_W-1:0];
          owpws_pkg::REG_SHORT:     tm_short = cfg_wdata[owpws_pkg::DUR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        owed_line_states.push_back(sender_step(in_opcode, in_data_byte));
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle tick, send, refused send, then shrink timing mid-start
    push_cmd(owpws_pkg::OP_TICK, 8'hFF);
    push_cmd(owpws_pkg::OP_SEND, 8'hFF);
    push_cmd(owpws_pkg::OP_SEND, 8'h00);
    push_ticks(2);
    drain();
    write_timing(owpws_pkg::REG_START_LOW, 16'd1);
    write_timing(owpws_pkg::REG_LONG, 16'd0);
    write_timing(owpws_pkg::REG_SHORT, 16'd0);
    write_timing(REG_UNUSED, 16'hFFFF);
    push_ticks(1 + 2 * owpws_pkg::DATA_BITS_DEF);
    push_cmd(owpws_pkg::OP_TICK, 8'h00);
    drain();

    while (useful < USEFUL_TARGET || phase_no < MIN_PHASES) begin
      if (phase_no == 1) begin
        stretch_then_shrink(8'h00);
      end else if (phase_no == 7) begin
        stretch_then_shrink(8'hFF);
      end else begin
        r = $urandom_range(99);
        write_timing(owpws_pkg::REG_START_LOW,
                     (r < 10) ? 16'd0 : 16'($urandom_range(12, 1)));
        r = $urandom_range(99);
        write_timing(owpws_pkg::REG_LONG, (r < 10) ? 16'd0 : 16'($urandom_range(6, 1)));
        r = $urandom_range(99);
        write_timing(owpws_pkg::REG_SHORT, (r < 10) ? 16'd0 : 16'($urandom_range(6, 1)));
        if ($urandom_range(3) == 0) write_timing(REG_UNUSED, 16'($urandom));
      end
      calm = (phase_no == 4 || phase_no == 5);
      repeat ($urandom_range(5, 2)) begin
        r = $urandom_range(99);
        if (r < 80) begin
          queue_transfer(8'($urandom), 1'b0);
        end else if (r < 90) begin
          queue_transfer(8'($urandom), 1'b1);
        end else begin
          repeat ($urandom_range(12, 1)) push_cmd(1'($urandom), 8'($urandom));
        end
      end
      if (phase_no == 2) hold_req = hold_req + 1;
      drain();
      phase_no++;
    end

    drain();
    repeat (10) @(posedge clk);
    bad_beats += owed_line_states.size();
    if (bad_beats == 0) begin
      $display("one_wire_pulse_width_sender_unit test passed");
    end else begin
      $display("one_wire_pulse_width_sender_unit test failed");
    end
    $finish;
  end

endmodule
